// ----- src/csps_pkg.sv -----
// Shared types, widths and constants for the cross-spectrum phase smoother.
package csps_pkg;

    localparam int BIN_W        = 11;
    localparam int SPEC_W       = 24;
    localparam int PHASE_W      = 18;
    localparam int WEIGHT_W     = 16;
    localparam int CFG_IDX_W    = 1;

    localparam int HALF_BINS_DEF = 2048;

    // Cross products and their sums
    localparam int PROD_W   = 2 * SPEC_W;
    localparam int CROSS_W  = PROD_W + 1;
    localparam int MAG_W    = PROD_W;
    localparam int NORM_MSB = 46;
    localparam int SHIFT_W  = 6;

    // CORDIC datapath
    localparam int CORD_W       = CROSS_W + 2;
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = 15;

    // Blend arithmetic
    localparam int Q_FRAC  = 15;
    localparam int DIFF_W  = PHASE_W + 1;
    localparam int WPROD_W = PHASE_W + WEIGHT_W + 1;
    localparam int ACC_W   = WPROD_W + 2;
    localparam int SCL_W   = ACC_W - Q_FRAC;

    // Phase unit is pi/65536
    localparam int PHASE_PI     = 65536;
    localparam int PHASE_TWO_PI = 131072;
    localparam int UNWRAP_LIMIT = 72089;

    localparam logic [STEP_W-1:0] STEP_ANGLE [CORDIC_STEPS] = '{
        15'd16384, 15'd9672, 15'd5110, 15'd2594, 15'd1302, 15'd652, 15'd326, 15'd163,
        15'd81,    15'd41,   15'd20,   15'd10,   15'd5,    15'd3,   15'd1,   15'd1
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEW_WEIGHT = 1'b0,
        CFG_OLD_WEIGHT = 1'b1
    } t_cfg_reg;

    localparam logic [WEIGHT_W-1:0] NEW_WEIGHT_RST = 16'd32768;
    localparam logic [WEIGHT_W-1:0] OLD_WEIGHT_RST = 16'd0;

    // Travels alongside each beat through the pipeline
    typedef struct packed {
        logic             valid;
        logic [BIN_W-1:0] bin;
    } t_tag;

endpackage

// ----- src/csps_angle.sv -----
// Pipelined cross-product, normalisation and vectoring CORDIC giving the bin phase.
module csps_angle (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  csps_pkg::t_tag                         i_tag,
    input  logic signed [csps_pkg::SPEC_W-1:0]     i_left_real,
    input  logic signed [csps_pkg::SPEC_W-1:0]     i_left_imag,
    input  logic signed [csps_pkg::SPEC_W-1:0]     i_right_real,
    input  logic signed [csps_pkg::SPEC_W-1:0]     i_right_imag,
    output csps_pkg::t_tag                         o_tag,
    output logic signed [csps_pkg::PHASE_W-1:0]    o_phase
);

    localparam int NSTEP = csps_pkg::CORDIC_STEPS;
    localparam logic signed [csps_pkg::PHASE_W-1:0] PI_POS =
        csps_pkg::PHASE_W'(csps_pkg::PHASE_PI);
    localparam logic signed [csps_pkg::PHASE_W-1:0] PI_NEG =
        csps_pkg::PHASE_W'(-csps_pkg::PHASE_PI);

    // Stage 1: products
    csps_pkg::t_tag                       r_a1_tag;
    logic signed [csps_pkg::PROD_W-1:0]   r_p_lr_rr, r_p_li_ri, r_p_rr_li, r_p_lr_ri;
    // Stage 2: cross terms
    csps_pkg::t_tag                       r_a2_tag;
    logic signed [csps_pkg::CROSS_W-1:0]  r_a2_x, r_a2_y;
    // Stage 3: combined magnitude
    csps_pkg::t_tag                       r_a3_tag;
    logic signed [csps_pkg::CROSS_W-1:0]  r_a3_x, r_a3_y;
    logic        [csps_pkg::MAG_W-1:0]    r_a3_mag;
    // Stage 4: shift amount
    csps_pkg::t_tag                       r_a4_tag;
    logic signed [csps_pkg::CROSS_W-1:0]  r_a4_x, r_a4_y;
    logic        [csps_pkg::SHIFT_W-1:0]  r_a4_shift;
    logic                                 r_a4_zero;
    // Stage 5: normalised vector
    csps_pkg::t_tag                       r_a5_tag;
    logic signed [csps_pkg::CROSS_W-1:0]  r_a5_x, r_a5_y;
    logic                                 r_a5_zero;
    // Stage 6: pre-rotation into the right half plane
    csps_pkg::t_tag                       r_a6_tag;
    logic signed [csps_pkg::CORD_W-1:0]   r_a6_x, r_a6_y;
    logic signed [csps_pkg::PHASE_W-1:0]  r_a6_z;
    logic                                 r_a6_zero;
    // CORDIC stages
    csps_pkg::t_tag                       r_c_tag  [NSTEP];
    logic signed [csps_pkg::CORD_W-1:0]   r_c_x    [NSTEP];
    logic signed [csps_pkg::CORD_W-1:0]   r_c_y    [NSTEP];
    logic signed [csps_pkg::PHASE_W-1:0]  r_c_z    [NSTEP];
    logic                                 r_c_zero [NSTEP];

    logic signed [csps_pkg::CROSS_W-1:0]  neg_x, neg_y;
    logic        [csps_pkg::MAG_W-1:0]    mag_x, mag_y;
    logic        [csps_pkg::SHIFT_W-1:0]  n_shift;
    logic signed [csps_pkg::CORD_W-1:0]   ext_x, ext_y;
    logic signed [csps_pkg::CORD_W-1:0]   n_a6_x, n_a6_y;
    logic signed [csps_pkg::PHASE_W-1:0]  n_a6_z;
    logic signed [csps_pkg::PHASE_W-1:0]  z_last, n_phase;

    // Tags carry the valid bit, so they alone take reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a1_tag <= '0;
            r_a2_tag <= '0;
            r_a3_tag <= '0;
            r_a4_tag <= '0;
            r_a5_tag <= '0;
            r_a6_tag <= '0;
        end else if (i_en) begin
            r_a1_tag <= i_tag;
            r_a2_tag <= r_a1_tag;
            r_a3_tag <= r_a2_tag;
            r_a4_tag <= r_a3_tag;
            r_a5_tag <= r_a4_tag;
            r_a6_tag <= r_a5_tag;
        end
    end

    always_comb begin
        neg_x = -r_a2_x;
        neg_y = -r_a2_y;
        mag_x = r_a2_x[csps_pkg::CROSS_W-1] ? neg_x[csps_pkg::MAG_W-1:0]
                                             : r_a2_x[csps_pkg::MAG_W-1:0];
        mag_y = r_a2_y[csps_pkg::CROSS_W-1] ? neg_y[csps_pkg::MAG_W-1:0]
                                             : r_a2_y[csps_pkg::MAG_W-1:0];
    end

    // Doublings needed to bring the leading one up to the normalisation bit
    always_comb begin
        n_shift = '0;
        for (int i = 0; i < csps_pkg::NORM_MSB; i++) begin
            if (r_a3_mag[i]) begin
                n_shift = csps_pkg::SHIFT_W'(csps_pkg::NORM_MSB - i);
            end
        end
        if (|r_a3_mag[csps_pkg::MAG_W-1:csps_pkg::NORM_MSB]) begin
            n_shift = '0;
        end
    end

    always_comb begin
        ext_x = csps_pkg::CORD_W'(r_a5_x);
        ext_y = csps_pkg::CORD_W'(r_a5_y);
        if (r_a5_x[csps_pkg::CROSS_W-1]) begin
            n_a6_x = -ext_x;
            n_a6_y = -ext_y;
            n_a6_z = r_a5_y[csps_pkg::CROSS_W-1] ? PI_NEG : PI_POS;
        end else begin
            n_a6_x = ext_x;
            n_a6_y = ext_y;
            n_a6_z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_lr_rr  <= i_left_real  * i_right_real;
            r_p_li_ri  <= i_left_imag  * i_right_imag;
            r_p_rr_li  <= i_right_real * i_left_imag;
            r_p_lr_ri  <= i_left_real  * i_right_imag;

            r_a2_x     <= csps_pkg::CROSS_W'(r_p_lr_rr) + csps_pkg::CROSS_W'(r_p_li_ri);
            r_a2_y     <= csps_pkg::CROSS_W'(r_p_rr_li) - csps_pkg::CROSS_W'(r_p_lr_ri);

            r_a3_x     <= r_a2_x;
            r_a3_y     <= r_a2_y;
            r_a3_mag   <= mag_x | mag_y;

            r_a4_x     <= r_a3_x;
            r_a4_y     <= r_a3_y;
            r_a4_shift <= n_shift;
            r_a4_zero  <= (r_a3_mag == '0);

            r_a5_x     <= r_a4_x <<< r_a4_shift;
            r_a5_y     <= r_a4_y <<< r_a4_shift;
            r_a5_zero  <= r_a4_zero;

            r_a6_x     <= n_a6_x;
            r_a6_y     <= n_a6_y;
            r_a6_z     <= n_a6_z;
            r_a6_zero  <= r_a5_zero;
        end
    end

    // One micro-rotation per stage
    for (genvar g = 0; g < NSTEP; g++) begin : g_step
        localparam logic signed [csps_pkg::PHASE_W-1:0] ANG =
            csps_pkg::PHASE_W'(csps_pkg::STEP_ANGLE[g]);

        csps_pkg::t_tag                       in_tag;
        logic signed [csps_pkg::CORD_W-1:0]   in_x, in_y, xs, ys;
        logic signed [csps_pkg::PHASE_W-1:0]  in_z;
        logic                                 in_zero;

        if (g == 0) begin : g_first
            assign in_tag  = r_a6_tag;
            assign in_x    = r_a6_x;
            assign in_y    = r_a6_y;
            assign in_z    = r_a6_z;
            assign in_zero = r_a6_zero;
        end else begin : g_next
            assign in_tag  = r_c_tag[g-1];
            assign in_x    = r_c_x[g-1];
            assign in_y    = r_c_y[g-1];
            assign in_z    = r_c_z[g-1];
            assign in_zero = r_c_zero[g-1];
        end

        assign xs = in_x >>> g;
        assign ys = in_y >>> g;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_c_tag[g] <= '0;
            end else if (i_en) begin
                r_c_tag[g] <= in_tag;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_c_zero[g] <= in_zero;
                if (!in_y[csps_pkg::CORD_W-1]) begin
                    r_c_x[g] <= in_x + ys;
                    r_c_y[g] <= in_y - xs;
                    r_c_z[g] <= in_z + ANG;
                end else begin
                    r_c_x[g] <= in_x - ys;
                    r_c_y[g] <= in_y + xs;
                    r_c_z[g] <= in_z - ANG;
                end
            end
        end
    end

    assign z_last = r_c_z[NSTEP-1];

    // Clamp to +-pi; a zero vector has no angle, so force zero
    always_comb begin
        priority if (r_c_zero[NSTEP-1]) begin
            n_phase = '0;
        end else if (z_last > PI_POS) begin
            n_phase = PI_POS;
        end else if (z_last < PI_NEG) begin
            n_phase = PI_NEG;
        end else begin
            n_phase = z_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_tag <= '0;
        end else if (i_en) begin
            o_tag <= r_c_tag[NSTEP-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_phase <= n_phase;
        end
    end

endmodule

// ----- src/cross_spectrum_phase_smoother.sv -----
// Cross-spectrum phase smoother: per-bin phase, unwrap, exponential blend and store.
//
// Accepts one FFT bin (left and right complex values) per clock while o_in_stall
// is low and returns one smoothed phase per bin, in units of pi/65536, at a rate
// of one per cycle while the output is not stalled; an accepted input beat passes
// through the input stage, the angle unit, the blend stage and the output register
// to its result beat. Per-bin phase history sits in a single-port-write memory of
// HALF_BINS entries; the read / blend / write-back loop on that memory runs with
// the last write forwarded, so the same bin may be sent on consecutive cycles.
// After reset the memory is swept to zero, during which input beats are stalled;
// configuration writes are taken throughout. Two result registers sit at the
// output, so input keeps flowing while one finished result waits to be taken.
// Weights are Q1.15 (register 0 is the weight of the new phase, register 1 of the
// stored phase) and are to be written only while the block is idle.
module cross_spectrum_phase_smoother #(
    parameter int HALF_BINS = csps_pkg::HALF_BINS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,

    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [csps_pkg::BIN_W-1:0]            i_bin_index,
    input  logic signed [csps_pkg::SPEC_W-1:0]    i_left_real,
    input  logic signed [csps_pkg::SPEC_W-1:0]    i_left_imag,
    input  logic signed [csps_pkg::SPEC_W-1:0]    i_right_real,
    input  logic signed [csps_pkg::SPEC_W-1:0]    i_right_imag,

    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [csps_pkg::BIN_W-1:0]            o_out_bin,
    output logic signed [csps_pkg::PHASE_W-1:0]   o_smoothed_phase,

    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [csps_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [csps_pkg::WEIGHT_W-1:0]         i_cfg_data
);

    localparam int AW    = $clog2(HALF_BINS);
    localparam int EXT_W = ((AW > csps_pkg::BIN_W) ? AW : csps_pkg::BIN_W) + 1;

    localparam logic [EXT_W-1:0] STORE_END = EXT_W'(HALF_BINS);
    localparam logic [AW-1:0]    CLR_LAST  = AW'(HALF_BINS - 1);

    localparam logic signed [csps_pkg::DIFF_W-1:0] UNWRAP_HI =
        csps_pkg::DIFF_W'(csps_pkg::UNWRAP_LIMIT);
    localparam logic signed [csps_pkg::DIFF_W-1:0] UNWRAP_LO =
        csps_pkg::DIFF_W'(-csps_pkg::UNWRAP_LIMIT);
    localparam logic signed [csps_pkg::SCL_W-1:0] S_PI_POS =
        csps_pkg::SCL_W'(csps_pkg::PHASE_PI);
    localparam logic signed [csps_pkg::SCL_W-1:0] S_PI_NEG =
        csps_pkg::SCL_W'(-csps_pkg::PHASE_PI);
    localparam logic signed [csps_pkg::SCL_W-1:0] S_TWO_PI =
        csps_pkg::SCL_W'(csps_pkg::PHASE_TWO_PI);

    // Configuration
    logic [csps_pkg::WEIGHT_W-1:0]          r_new_weight, r_old_weight;

    // Pipeline control
    logic                                   adv, in_take;

    // Input stage
    csps_pkg::t_tag                         r_s0_tag;
    logic signed [csps_pkg::SPEC_W-1:0]     r_s0_lr, r_s0_li, r_s0_rr, r_s0_ri;

    // Angle unit output
    csps_pkg::t_tag                         ang_tag;
    logic signed [csps_pkg::PHASE_W-1:0]    ang_phase;

    // Blend stage
    csps_pkg::t_tag                         r_m_tag;
    logic signed [csps_pkg::PHASE_W-1:0]    r_m_phase;
    logic signed [csps_pkg::WPROD_W-1:0]    r_m_prod;

    // Phase memory
    logic [csps_pkg::PHASE_W-1:0]           r_phase_mem [HALF_BINS];
    logic [csps_pkg::PHASE_W-1:0]           r_mem_q;
    logic [AW-1:0]                          rd_addr, wr_addr;
    logic                                   wr_en;
    logic [csps_pkg::PHASE_W-1:0]           wr_data;
    logic                                   r_clearing;
    logic [AW-1:0]                          r_clr_addr;
    logic                                   r_wr_valid;
    logic [AW-1:0]                          r_wr_addr;
    logic [csps_pkg::PHASE_W-1:0]           r_wr_data;

    // Blend datapath
    logic [EXT_W-1:0]                       a_ext, m_ext;
    logic [AW-1:0]                          m_addr;
    logic                                   m_in_store, fwd_hit;
    logic signed [csps_pkg::PHASE_W-1:0]    stored;
    logic signed [csps_pkg::DIFF_W-1:0]     diff;
    logic signed [csps_pkg::WPROD_W-1:0]    old_prod;
    logic signed [csps_pkg::ACC_W-1:0]      turn, adj, acc;
    logic signed [csps_pkg::SCL_W-1:0]      scaled, wrapped, sat;
    logic signed [csps_pkg::PHASE_W-1:0]    n_phase;
    logic                                   res_v;

    // Output and skid registers
    logic                                   r_out_valid, r_skid_valid;
    logic [csps_pkg::BIN_W-1:0]             r_out_bin, r_skid_bin;
    logic signed [csps_pkg::PHASE_W-1:0]    r_out_phase, r_skid_phase;
    logic                                   out_take;

    // The whole pipeline moves while the skid register is free
    assign adv        = !r_skid_valid;
    assign o_in_stall = r_clearing || !adv;
    assign in_take    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_new_weight <= csps_pkg::NEW_WEIGHT_RST;
            r_old_weight <= csps_pkg::OLD_WEIGHT_RST;
        end else if (i_cfg_valid) begin
            unique case (csps_pkg::t_cfg_reg'(i_cfg_index))
                csps_pkg::CFG_NEW_WEIGHT: r_new_weight <= i_cfg_data;
                csps_pkg::CFG_OLD_WEIGHT: r_old_weight <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_tag <= '0;
        end else if (adv) begin
            r_s0_tag.valid <= in_take;
            r_s0_tag.bin   <= i_bin_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s0_lr <= i_left_real;
            r_s0_li <= i_left_imag;
            r_s0_rr <= i_right_real;
            r_s0_ri <= i_right_imag;
        end
    end

    csps_angle u_angle (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (adv),
        .i_tag        (r_s0_tag),
        .i_left_real  (r_s0_lr),
        .i_left_imag  (r_s0_li),
        .i_right_real (r_s0_rr),
        .i_right_imag (r_s0_ri),
        .o_tag        (ang_tag),
        .o_phase      (ang_phase)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tag <= '0;
        end else if (adv) begin
            r_m_tag <= ang_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m_phase <= ang_phase;
            r_m_prod  <= ang_phase * $signed({1'b0, r_new_weight});
        end
    end

    // Read for the beat entering the blend stage; re-read the held one when frozen
    assign a_ext      = EXT_W'(ang_tag.bin);
    assign m_ext      = EXT_W'(r_m_tag.bin);
    assign m_addr     = m_ext[AW-1:0];
    assign m_in_store = (m_ext < STORE_END);
    assign rd_addr    = adv ? a_ext[AW-1:0] : m_addr;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_phase_mem[wr_addr] <= wr_data;
        end
        r_mem_q <= r_phase_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == CLR_LAST) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // The read above misses a write made at the same edge; take that one from here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_valid <= 1'b0;
        end else if (wr_en && !r_clearing) begin
            r_wr_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && !r_clearing) begin
            r_wr_addr <= wr_addr;
            r_wr_data <= wr_data;
        end
    end

    always_comb begin
        fwd_hit = r_wr_valid && (r_wr_addr == m_addr);
        if (!m_in_store) begin
            stored = '0;
        end else if (fwd_hit) begin
            stored = $signed(r_wr_data);
        end else begin
            stored = $signed(r_mem_q);
        end

        diff     = csps_pkg::DIFF_W'(r_m_phase) - csps_pkg::DIFF_W'(stored);
        old_prod = stored * $signed({1'b0, r_old_weight});

        // Unwrapping by 2*pi shifts the new-phase product by new_weight << 17
        turn = csps_pkg::ACC_W'($signed({1'b0, r_new_weight, 17'b0}));
        priority if (diff < UNWRAP_LO) begin
            adj = turn;
        end else if (diff > UNWRAP_HI) begin
            adj = -turn;
        end else begin
            adj = '0;
        end

        acc    = csps_pkg::ACC_W'(r_m_prod) + csps_pkg::ACC_W'(old_prod) + adj;
        scaled = acc[csps_pkg::ACC_W-1:csps_pkg::Q_FRAC];

        priority if (scaled < S_PI_NEG) begin
            wrapped = scaled + S_TWO_PI;
        end else if (scaled > S_PI_POS) begin
            wrapped = scaled - S_TWO_PI;
        end else begin
            wrapped = scaled;
        end

        // Weights summing past one can leave the result outside +-pi after one wrap
        priority if (wrapped > S_PI_POS) begin
            sat = S_PI_POS;
        end else if (wrapped < S_PI_NEG) begin
            sat = S_PI_NEG;
        end else begin
            sat = wrapped;
        end

        if (r_m_tag.bin == '0) begin
            n_phase = '0;
        end else begin
            n_phase = sat[csps_pkg::PHASE_W-1:0];
        end
    end

    always_comb begin
        if (r_clearing) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = adv && r_m_tag.valid && m_in_store;
            wr_addr = m_addr;
            wr_data = n_phase;
        end
    end

    assign res_v    = adv && r_m_tag.valid;
    assign out_take = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || out_take) begin
            r_out_valid <= res_v;
        end else begin
            r_skid_valid <= res_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out_bin   <= r_skid_bin;
                r_out_phase <= r_skid_phase;
            end
        end else if (!r_out_valid || out_take) begin
            r_out_bin   <= r_m_tag.bin;
            r_out_phase <= n_phase;
        end else begin
            r_skid_bin   <= r_m_tag.bin;
            r_skid_phase <= n_phase;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_bin        = r_out_bin;
    assign o_smoothed_phase = r_out_phase;

endmodule
